>>> sv/assert_macros.svh
// assertion macros shared by the sobel gradient rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SGR_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SGR_ASSERT_NXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sgr_pkg.sv
// shared types and constants of the sobel gradient block
package sgr_pkg;

  // default frame limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // field widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 10;
  localparam int GRAD_W    = 11;
  localparam int EMIT_N    = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [PIX_W-1:0] pix_t;

  // one pixel's work: updated window, its coordinates and which gradients to emit
  // emit bit 0: (r-1, c-1), bit 1: (r-1, c), bit 2: (r, c-1), bit 3: (r, c)
  typedef struct packed {
    pix_t [8:0]          win;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [EMIT_N-1:0]   emit;
  } job_t;

  // queue fill status seen by the front
  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } q_stat_t;

endpackage

>>> sv/sgr_front.sv
// front: pixel intake, raster counters, line stores, window and job building
module sgr_front #(
  parameter int MAX_WIDTH  = sgr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sgr_pkg::PIX_W-1:0]  in_pixel,
  input  logic [sgr_pkg::CFG_W-1:0]  frame_width,
  input  logic [sgr_pkg::CFG_W-1:0]  frame_height,
  input  sgr_pkg::q_stat_t           q_stat,
  output logic                       q_push,
  output sgr_pkg::job_t              q_job
);
  import sgr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // raster counters
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  // stage one registers
  logic              s1_v_r;
  pix_t              s1_pix_r;
  logic [CW-1:0]     s1_c_r;
  logic              s1_r_zero_r;
  logic              s1_c_zero_r;
  logic [COORD_W-1:0] s1_row_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [EMIT_N-1:0] s1_emit_r;
  logic              byp_r;
  pix_t              byp_older_r;
  pix_t              byp_newer_r;
  pix_t              rd_older_r;
  pix_t              rd_newer_r;
  pix_t [8:0]        win_r;

  // line stores
  pix_t line_older [MAX_WIDTH];
  pix_t line_newer [MAX_WIDTH];

  logic [31:0]   w_full;
  logic [31:0]   h_full;
  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [CW-1:0] c_inc;
  logic [RW-1:0] r_inc;
  logic [RW-1:0] row_inc;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic          r_gt0;
  logic          c_gt0;
  logic          c_last;
  logic          r_last;
  logic [EMIT_N-1:0] emit0;
  logic          accept;
  logic [QLVL_W:0] occ;
  pix_t          top;
  pix_t          mid;
  pix_t          top_raw;
  pix_t          mid_raw;
  pix_t [8:0]    win_nxt;

  // clamp the frame size into 1..MAX
  always_comb begin
    if (frame_width == '0) begin
      w_full = 32'd1;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(frame_width);
    end
    if (frame_height == '0) begin
      h_full = 32'd1;
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(frame_height);
    end
  end
  assign w = w_full[CW-1:0];
  assign h = h_full[RW-1:0];

  // position of the incoming pixel, rewrapped if the size shrank
  assign row_inc = row_r + RW'(1);
  always_comb begin
    c0 = col_r;
    r0 = row_r;
    if (col_r >= w) begin
      c0 = '0;
      r0 = row_inc;
    end
    if (r0 >= h) begin
      r0 = '0;
    end
  end

  // classify: which gradients this pixel releases
  assign r_gt0  = (r0 != '0);
  assign c_gt0  = (c0 != '0);
  assign c_last = (c0 == w - CW'(1));
  assign r_last = (r0 == h - RW'(1));
  assign emit0  = {r_last & c_last, r_last & c_gt0, r_gt0 & c_last, r_gt0 & c_gt0};

  // counters after this pixel
  assign c_inc = c0 + CW'(1);
  assign r_inc = r0 + RW'(1);
  always_comb begin
    col_nxt = c_inc;
    row_nxt = r0;
    if (c_inc >= w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h) ? '0 : r_inc;
    end
  end

  // intake: room for the item in flight and the queue
  assign occ      = {1'b0, q_stat.level} + (QLVL_W + 1)'(s1_v_r);
  assign in_stall = (occ >= (QLVL_W + 1)'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // stage one payload, with a bypass when the store entry is written this edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r    <= in_pixel;
      s1_c_r      <= c0;
      s1_r_zero_r <= !r_gt0;
      s1_c_zero_r <= !c_gt0;
      s1_row_r    <= COORD_W'(r0);
      s1_col_r    <= COORD_W'(c0);
      s1_emit_r   <= emit0;
      byp_r       <= s1_v_r && (s1_c_r == c0);
      byp_older_r <= mid;
      byp_newer_r <= s1_pix_r;
    end
  end

  // line store access: read on intake, write in the cycle after
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_older[s1_c_r[AW-1:0]] <= mid;
      line_newer[s1_c_r[AW-1:0]] <= s1_pix_r;
    end
    if (accept) begin
      rd_older_r <= line_older[c0[AW-1:0]];
      rd_newer_r <= line_newer[c0[AW-1:0]];
    end
  end

  // column of the window, with the top row replicated
  assign top_raw = byp_r ? byp_older_r : rd_older_r;
  assign mid_raw = byp_r ? byp_newer_r : rd_newer_r;
  assign top     = s1_r_zero_r ? s1_pix_r : top_raw;
  assign mid     = s1_r_zero_r ? s1_pix_r : mid_raw;

  // window shift, or fill at the left edge
  always_comb begin
    win_nxt = win_r;
    if (s1_c_zero_r) begin
      for (int j = 0; j < 3; j++) begin
        win_nxt[j]     = top;
        win_nxt[3 + j] = mid;
        win_nxt[6 + j] = s1_pix_r;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i * 3]     = win_r[i * 3 + 1];
        win_nxt[i * 3 + 1] = win_r[i * 3 + 2];
      end
      win_nxt[2] = top;
      win_nxt[5] = mid;
      win_nxt[8] = s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  // job out to the queue
  assign q_push     = s1_v_r && (s1_emit_r != '0);
  assign q_job.win  = win_nxt;
  assign q_job.row  = s1_row_r;
  assign q_job.col  = s1_col_r;
  assign q_job.emit = s1_emit_r;

endmodule

>>> sv/sgr_queue.sv
// short job queue between front and back
module sgr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sgr_pkg::job_t    push_job,
  input  logic             pop,
  output logic             q_valid,
  output sgr_pkg::job_t    q_job,
  output sgr_pkg::q_stat_t q_stat
);
  import sgr_pkg::*;

  `include "assert_macros.svh"

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QLVL_W-1:0] level_r;
  logic [QLVL_W-1:0] level_nxt;

  // occupancy
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QLVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign q_valid      = (level_r != '0);
  assign q_job        = slot_r[rd_ptr_r];
  assign q_stat.level = level_r;

  `SGR_ASSERT_IMP(a_no_overflow, push && !pop, level_r != QLVL_W'(QUEUE_DEPTH), "queue overflow")
  `SGR_ASSERT_IMP(a_no_underflow, pop, level_r != '0, "queue underflow")

endmodule

>>> sv/sgr_back.sv
// back: walks each job's gradients and drives the result register
module sgr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  sgr_pkg::job_t                      q_job,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sgr_pkg::COORD_W-1:0]        out_row,
  output logic [sgr_pkg::COORD_W-1:0]        out_col,
  output logic signed [sgr_pkg::GRAD_W-1:0]  out_grad_x,
  output logic signed [sgr_pkg::GRAD_W-1:0]  out_grad_y,
  output logic                               out_burst_last
);
  import sgr_pkg::*;

  `include "assert_macros.svh"

  logic              cur_v_r;
  logic              cur_v_nxt;
  job_t              cur_r;
  logic [EMIT_N-1:0] pend_r;
  logic [EMIT_N-1:0] pend_clr;
  logic [1:0]        k;
  logic              out_free;
  logic              fire;
  logic              done;

  logic              out_valid_r;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [GRAD_W-1:0] gx_r;
  logic [GRAD_W-1:0] gy_r;
  logic              last_r;

  logic [1:0]        rt, rm;
  logic [1:0]        cl, cm;
  logic [GRAD_W-1:0] sx_r, sx_l, sy_b, sy_t;
  logic [GRAD_W-1:0] gx;
  logic [GRAD_W-1:0] gy;

  // window tap at row i, column j
  function automatic logic [GRAD_W-1:0] tap(pix_t [8:0] win, logic [1:0] i, logic [1:0] j);
    logic [3:0] idx;
    idx = 4'(i) * 4'd3 + 4'(j);
    return GRAD_W'(win[idx]);
  endfunction

  // lowest pending gradient goes first
  always_comb begin
    k = 2'd3;
    for (int b = EMIT_N - 1; b >= 0; b--) begin
      if (pend_r[b]) begin
        k = 2'(b);
      end
    end
  end
  assign pend_clr = pend_r & ~(EMIT_N'(1) << k);

  // sequencing
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = cur_v_r && out_free;
  assign done      = fire && (pend_clr == '0);
  assign pop       = q_valid && (!cur_v_r || done);
  assign cur_v_nxt = pop ? 1'b1 : (done ? 1'b0 : cur_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= q_job;
      pend_r <= q_job.emit;
    end else if (fire) begin
      pend_r <= pend_clr;
    end
  end

  // rows and columns of the 3x3 taps, with bottom row and right column replicated
  assign rt = k[1] ? 2'd1 : 2'd0;
  assign rm = k[1] ? 2'd2 : 2'd1;
  assign cl = k[0] ? 2'd1 : 2'd0;
  assign cm = k[0] ? 2'd2 : 2'd1;

  // sobel sums
  assign sx_r = tap(cur_r.win, rt, 2'd2) + (tap(cur_r.win, rm, 2'd2) << 1)
              + tap(cur_r.win, 2'd2, 2'd2);
  assign sx_l = tap(cur_r.win, rt, cl) + (tap(cur_r.win, rm, cl) << 1)
              + tap(cur_r.win, 2'd2, cl);
  assign sy_b = tap(cur_r.win, 2'd2, cl) + (tap(cur_r.win, 2'd2, cm) << 1)
              + tap(cur_r.win, 2'd2, 2'd2);
  assign sy_t = tap(cur_r.win, rt, cl) + (tap(cur_r.win, rt, cm) << 1)
              + tap(cur_r.win, rt, 2'd2);
  assign gx   = sx_r - sx_l;
  assign gy   = sy_b - sy_t;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      row_r  <= k[1] ? cur_r.row : cur_r.row - COORD_W'(1);
      col_r  <= k[0] ? cur_r.col : cur_r.col - COORD_W'(1);
      gx_r   <= gx;
      gy_r   <= gy;
      last_r <= (pend_clr == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_grad_x     = signed'(gx_r);
  assign out_grad_y     = signed'(gy_r);
  assign out_burst_last = last_r;

  `SGR_ASSERT_IMP(a_busy_has_work, cur_v_r, pend_r != '0, "job held with nothing pending")
  `SGR_ASSERT_NXT(a_job_kept, cur_v_r && !done, cur_v_r, "job dropped before its last item")

endmodule

>>> sv/sobel_gradient_3x3_replicate_core.sv
// top level of the streaming 3x3 sobel gradient with replicated borders
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------------
//   input    | in_valid / in_stall       | in_pixel
//   result   | out_valid / out_stall     | out_row, out_col, out_grad_x, out_grad_y,
//            |                           | out_burst_last
//   config   | cfg_we                    | cfg_addr, cfg_wdata
//
// the back issues one result item per cycle unless the output stalls; a pixel
// releases one result in inner rows, two at an inner row's end and across the last
// row, up to four at the end of the last row
// the line stores are read on intake and written in the cycle after
// the four-job queue absorbs bursts
// reset is synchronous and needs no clearing pass; line store contents start undefined
// a stalled result holds in the output register while the queue keeps taking jobs until full
module sobel_gradient_3x3_replicate_core #(
  parameter int MAX_WIDTH  = sgr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sgr_pkg::PIX_W-1:0]          in_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sgr_pkg::COORD_W-1:0]        out_row,
  output logic [sgr_pkg::COORD_W-1:0]        out_col,
  output logic signed [sgr_pkg::GRAD_W-1:0]  out_grad_x,
  output logic signed [sgr_pkg::GRAD_W-1:0]  out_grad_y,
  output logic                               out_burst_last,
  input  logic                               cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [sgr_pkg::CFG_W-1:0]          cfg_wdata
);
  import sgr_pkg::*;

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;

  logic    q_push;
  job_t    push_job;
  logic    q_pop;
  logic    q_valid;
  job_t    q_job;
  q_stat_t q_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // intake and classification
  sgr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  // job queue
  sgr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_stat   (q_stat)
  );

  // gradient issue
  sgr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_burst_last (out_burst_last)
  );

endmodule
